>>> design/kruskal_union_find_edge_filter_assert.svh
// Assertion macros shared by the edge filter RTL.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_ASSERT_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define KUF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kuf: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define KUF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kuf: next-cycle check failed");

`endif

>>> design/kuf_pkg.sv
// Types, codes and microcode ROM for the union-find edge filter.
package kuf_pkg;

    localparam int NODE_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 24;
    localparam int COUNT_W  = 8;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_CYCLE  = 2'd1,
        ST_BAD    = 2'd2,
        ST_CLEAR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_SWEEP,
        OP_CHECK_A,
        OP_CHECK_B,
        OP_LINK_LO,
        OP_LINK_HI,
        OP_RESULT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_SWEEP_MORE,
        C_NOT_ROOT,
        C_IS_CLEAR,
        C_IS_BAD,
        C_IS_CYCLE,
        C_OUT_FREE
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step P_INIT    = 4'd0;
    localparam t_step P_IDLE    = 4'd1;
    localparam t_step P_DISP1   = 4'd2;
    localparam t_step P_DISP2   = 4'd3;
    localparam t_step P_FA_RD   = 4'd4;
    localparam t_step P_FA_CK   = 4'd5;
    localparam t_step P_FB_RD   = 4'd6;
    localparam t_step P_FB_CK   = 4'd7;
    localparam t_step P_LINK_LO = 4'd8;
    localparam t_step P_LINK_HI = 4'd9;
    localparam t_step P_CLR     = 4'd10;
    localparam t_step P_RES     = 4'd11;
    localparam t_step P_RETRY   = 4'd12;

    // Taken jump goes to target, otherwise to the next step.
    function automatic t_uword uc_rom(input t_step pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: P_IDLE};
        case (pc)
            P_INIT:    w = '{op: OP_SWEEP,   cond: C_SWEEP_MORE, target: P_INIT};
            P_IDLE:    w = '{op: OP_WAIT,    cond: C_NO_IN,      target: P_IDLE};
            P_DISP1:   w = '{op: OP_NOP,     cond: C_IS_CLEAR,   target: P_CLR};
            P_DISP2:   w = '{op: OP_NOP,     cond: C_IS_BAD,     target: P_RES};
            P_FA_RD:   w = '{op: OP_NOP,     cond: C_NEVER,      target: P_IDLE};
            P_FA_CK:   w = '{op: OP_CHECK_A, cond: C_NOT_ROOT,   target: P_FA_RD};
            P_FB_RD:   w = '{op: OP_NOP,     cond: C_NEVER,      target: P_IDLE};
            P_FB_CK:   w = '{op: OP_CHECK_B, cond: C_NOT_ROOT,   target: P_FB_RD};
            P_LINK_LO: w = '{op: OP_LINK_LO, cond: C_IS_CYCLE,   target: P_RES};
            P_LINK_HI: w = '{op: OP_LINK_HI, cond: C_ALWAYS,     target: P_RES};
            P_CLR:     w = '{op: OP_SWEEP,   cond: C_SWEEP_MORE, target: P_CLR};
            P_RES:     w = '{op: OP_RESULT,  cond: C_OUT_FREE,   target: P_IDLE};
            P_RETRY:   w = '{op: OP_NOP,     cond: C_ALWAYS,     target: P_RES};
            default:   w = '{op: OP_NOP,     cond: C_ALWAYS,     target: P_INIT};
        endcase
        return w;
    endfunction

endpackage

>>> design/kuf_set_mem.sv
// Single-port-write, registered-read table for parent and set size.
module kuf_set_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/kruskal_union_find_edge_filter.sv
// Top level: microcoded union-find engine that filters edges for Kruskal's MST.
//
//  channel   direction  handshake                    payload
//  ------------------------------------------------------------------------------------
//  in        in         i_in_valid / o_in_stall      i_action i_node_a i_node_b i_edge_weight
//  out       out        o_out_valid / i_out_stall    o_status o_total_weight o_tree_edge_count
//  cfg       in         i_cfg_we                     i_cfg_data (num_nodes)
//
// One item at a time. An edge walks the parents of node a, then of node b, each hop a read
// step and a check step through the registered table read; a cycle skips the second link
// step. A bad node goes straight to the result; a clear first sweeps every table entry.
// After reset a clearing pass over all NODE_SLOTS entries runs before the first transfer is taken.
// Reset is synchronous, active low. A finished result waits in the output register while
// the next item is taken; the sequencer holds only if a second result finds it still full.
module kruskal_union_find_edge_filter #(
    parameter int NODE_SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kuf_pkg::NODE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [kuf_pkg::NODE_W-1:0]    i_node_a,
    input  logic [kuf_pkg::NODE_W-1:0]    i_node_b,
    input  logic [kuf_pkg::WEIGHT_W-1:0]  i_edge_weight,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kuf_pkg::STATUS_W-1:0]  o_status,
    output logic [kuf_pkg::TOTAL_W-1:0]   o_total_weight,
    output logic [kuf_pkg::COUNT_W-1:0]   o_tree_edge_count
);

    import kuf_pkg::*;

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam int DW    = SIZE_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_SLOTS - 1);

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  parent;
    } t_entry;

    t_step               r_pc;
    logic [IDX_W-1:0]    r_cnt;
    logic [NODE_W-1:0]   r_num_nodes;
    logic [TOTAL_W-1:0]  r_sum;
    logic [COUNT_W-1:0]  r_count;
    t_status             r_status;
    logic [IDX_W-1:0]    r_cur;
    logic [IDX_W-1:0]    r_b;
    logic [IDX_W-1:0]    r_ra;
    logic [IDX_W-1:0]    r_rb;
    logic [SIZE_W-1:0]   r_sa;
    logic [SIZE_W-1:0]   r_sb;
    logic [WEIGHT_W-1:0] r_w;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TOTAL_W-1:0]  r_out_total;
    logic [COUNT_W-1:0]  r_out_count;

    t_uword              uw;
    t_step               n_pc;
    logic                cond_hit;
    logic                in_xfer;
    logic                out_free;
    logic                is_root;
    logic                bad_node;
    t_entry              rd_entry;
    logic [DW-1:0]       rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic [IDX_W-1:0]    lo_root;
    logic [IDX_W-1:0]    hi_root;
    logic [SIZE_W-1:0]   lo_size;
    logic [SIZE_W:0]     size_sum;
    logic [SIZE_W-1:0]   size_sat;
    logic [TOTAL_W:0]    wsum;

    function automatic logic node_ok(input logic [NODE_W-1:0] n,
                                     input logic [NODE_W-1:0] lim);
        return (n != '0) && (n <= lim) && (32'(n) < NODE_SLOTS);
    endfunction

    assign uw       = uc_rom(r_pc);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_entry = t_entry'(rd_data);
    assign is_root  = (rd_entry.parent == r_cur);
    assign bad_node = !node_ok(i_node_a, r_num_nodes) || !node_ok(i_node_b, r_num_nodes);

    // Union by size, ties hang the first root under the second.
    assign lo_root  = (r_sa > r_sb) ? r_rb : r_ra;
    assign hi_root  = (r_sa > r_sb) ? r_ra : r_rb;
    assign lo_size  = (r_sa > r_sb) ? r_sb : r_sa;
    assign size_sum = {1'b0, r_sa} + {1'b0, r_sb};
    assign size_sat = size_sum[SIZE_W] ? {SIZE_W{1'b1}} : size_sum[SIZE_W-1:0];
    assign wsum     = {1'b0, r_sum} + (TOTAL_W + 1)'(r_w);

    always_comb begin
        unique case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_IN:      cond_hit = !in_xfer;
            C_SWEEP_MORE: cond_hit = (r_cnt != LAST_IDX);
            C_NOT_ROOT:   cond_hit = !is_root;
            C_IS_CLEAR:   cond_hit = (r_status == ST_CLEAR);
            C_IS_BAD:     cond_hit = (r_status == ST_BAD);
            C_IS_CYCLE:   cond_hit = (r_status == ST_CYCLE);
            C_OUT_FREE:   cond_hit = out_free;
            default:      cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? uw.target : t_step'(r_pc + 1'b1);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '{size: SIZE_W'(1), parent: r_cnt};
        unique case (uw.op)
            OP_SWEEP: begin
                mem_we = 1'b1;
            end
            OP_LINK_LO: begin
                mem_we    = (r_status != ST_CYCLE);
                mem_waddr = lo_root;
                mem_wdata = '{size: lo_size, parent: hi_root};
            end
            OP_LINK_HI: begin
                mem_we    = 1'b1;
                mem_waddr = hi_root;
                mem_wdata = '{size: size_sat, parent: hi_root};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    kuf_set_mem #(
        .DEPTH (NODE_SLOTS),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_set_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cur),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= P_INIT;
            r_cnt       <= '0;
            r_num_nodes <= NODE_W'(255);
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                r_num_nodes <= i_cfg_data;
            end
            unique case (uw.op)
                OP_WAIT: begin
                    if (in_xfer) begin
                        r_cur <= IDX_W'(i_node_a);
                        r_b   <= IDX_W'(i_node_b);
                        r_w   <= i_edge_weight;
                        if (!i_action) begin
                            r_status <= ST_CLEAR;
                        end else if (bad_node) begin
                            r_status <= ST_BAD;
                        end else begin
                            r_status <= ST_ACCEPT;
                        end
                    end
                end
                OP_SWEEP: begin
                    r_cnt   <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
                    r_sum   <= '0;
                    r_count <= '0;
                end
                OP_CHECK_A: begin
                    if (is_root) begin
                        r_ra  <= r_cur;
                        r_sa  <= rd_entry.size;
                        r_cur <= r_b;
                    end else begin
                        r_cur <= rd_entry.parent;
                    end
                end
                OP_CHECK_B: begin
                    if (is_root) begin
                        r_rb <= r_cur;
                        r_sb <= rd_entry.size;
                        if (r_cur == r_ra) begin
                            r_status <= ST_CYCLE;
                        end
                    end else begin
                        r_cur <= rd_entry.parent;
                    end
                end
                OP_LINK_HI: begin
                    r_sum <= wsum[TOTAL_W] ? {TOTAL_W{1'b1}} : wsum[TOTAL_W-1:0];
                    if (r_count != {COUNT_W{1'b1}}) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (uw.op == OP_RESULT && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_total  <= r_sum;
                r_out_count  <= r_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall        = (uw.op != OP_WAIT);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_total_weight    = r_out_total;
    assign o_tree_edge_count = r_out_count;

`include "kruskal_union_find_edge_filter_assert.svh"

    `KUF_ASSERT_NOW(a_link_distinct_roots, (r_pc == P_LINK_HI), (r_ra != r_rb))
    `KUF_ASSERT_NEXT(a_count_monotonic, (r_pc != P_CLR && r_pc != P_INIT), (r_count >= $past(r_count)))
    `KUF_ASSERT_NEXT(a_result_loaded, (r_pc == P_RES && out_free), (o_out_valid))

endmodule
